// ===== rtl/pwq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Priority wait queue package
// Request and status codes and the control and status structs shared between
// the controller and the datapath.
// ----------------------------------------------------------------------------
package pwq_pkg;

    localparam logic       REQ_INSERT  = 1'b0;
    localparam logic       REQ_EXTRACT = 1'b1;

    localparam logic [1:0] ST_INSERTED  = 2'd0;
    localparam logic [1:0] ST_EXTRACTED = 2'd1;
    localparam logic [1:0] ST_EMPTY     = 2'd2;
    localparam logic [1:0] ST_FULL      = 2'd3;

    typedef struct packed {
        logic ins;
        logic ext;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_stat;

endpackage

// ===== rtl/pwq_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Priority wait queue datapath
// Sorted shift-register chain of task slots with an occupancy counter. Every
// slot compares its priority with the new word in parallel and either holds,
// takes the new word or takes a neighboring slot's word.
// ----------------------------------------------------------------------------
module pwq_datapath #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  pwq_pkg::t_cmd                    i_cmd,
    input  logic [7:0]                       i_task_id,
    input  logic [7:0]                       i_task_priority,
    output pwq_pkg::t_stat                   o_stat,
    output logic [7:0]                       o_head_task,
    output logic [$clog2(QUEUE_DEPTH+1)-1:0] o_count
);
    import pwq_pkg::*;

    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic [7:0]          r_task [QUEUE_DEPTH];
    logic [7:0]          r_prio [QUEUE_DEPTH];
    logic [7:0]          n_task [QUEUE_DEPTH];
    logic [7:0]          n_prio [QUEUE_DEPTH];
    logic [CW-1:0]       r_count;
    logic [CW-1:0]       n_count;
    logic [QUEUE_DEPTH-1:0] lower;

    always_comb begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            lower[i] = (CW'(i) >= r_count) || (r_prio[i] < i_task_priority);
        end
    end

    always_comb begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            n_task[i] = r_task[i];
            n_prio[i] = r_prio[i];
        end
        n_count = r_count;
        if (i_cmd.ins) begin
            n_count = r_count + CW'(1);
            if (lower[0]) begin
                n_task[0] = i_task_id;
                n_prio[0] = i_task_priority;
            end
            for (int i = 1; i < QUEUE_DEPTH; i++) begin
                if (lower[i] && !lower[i-1]) begin
                    n_task[i] = i_task_id;
                    n_prio[i] = i_task_priority;
                end else if (lower[i]) begin
                    n_task[i] = r_task[i-1];
                    n_prio[i] = r_prio[i-1];
                end
            end
        end else if (i_cmd.ext) begin
            n_count = r_count - CW'(1);
            for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
                n_task[i] = r_task[i+1];
                n_prio[i] = r_prio[i+1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            r_task[i] <= n_task[i];
            r_prio[i] <= n_prio[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    assign o_stat.full  = (r_count == CW'(QUEUE_DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign o_head_task  = r_task[0];
    assign o_count      = r_count;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(QUEUE_DEPTH))
        else $error("Queue count exceeds depth.");

    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_cmd.ins && i_cmd.ext))
        else $error("Insert and extract issued together.");

    a_ins_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.ins |=> r_count == $past(r_count) + CW'(1))
        else $error("Insert did not grow the queue by one.");

    a_ext_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.ext |=> r_count == $past(r_count) - CW'(1))
        else $error("Extract did not shrink the queue by one.");

    a_head_sorted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count >= CW'(2) |-> r_prio[0] >= r_prio[1])
        else $error("Head slot is not the most urgent.");
`endif

endmodule

// ===== rtl/pwq_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Priority wait queue controller
// Decodes each accepted request against the full and empty flags into a
// datapath command and registers the result word with its strobe.
// ----------------------------------------------------------------------------
module pwq_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    input  logic           i_req_type,
    input  pwq_pkg::t_stat i_stat,
    input  logic [7:0]     i_head_task,
    output pwq_pkg::t_cmd  o_cmd,
    output logic           o_valid,
    output logic [1:0]     o_status,
    output logic [7:0]     o_out_task_id
);
    import pwq_pkg::*;

    logic       accept;
    logic       r_valid;
    logic [1:0] r_status;
    logic [1:0] n_status;
    logic [7:0] r_out_id;
    logic [7:0] n_out_id;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_comb begin
        o_cmd.ins = 1'b0;
        o_cmd.ext = 1'b0;
        n_status  = ST_INSERTED;
        n_out_id  = '0;
        case (i_req_type)
            REQ_INSERT: begin
                if (i_stat.full) begin
                    n_status = ST_FULL;
                end else begin
                    o_cmd.ins = accept;
                end
            end
            REQ_EXTRACT: begin
                if (i_stat.empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    o_cmd.ext = accept;
                    n_status  = ST_EXTRACTED;
                    n_out_id  = i_head_task;
                end
            end
            default: begin
                n_status = ST_INSERTED;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_status <= n_status;
            r_out_id <= n_out_id;
        end
    end

    assign o_valid       = r_valid;
    assign o_status      = r_status;
    assign o_out_task_id = r_out_id;

endmodule

// ===== rtl/priority_wait_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Priority wait queue
// Bounded waiting queue of task identifiers sorted by priority, ties served
// in arrival order.
// ----------------------------------------------------------------------------
// A request word is taken at a rising edge where start is high and busy is
// low. i_req_type selects insert or extract; insert carries i_task_id and
// i_task_priority, where a larger priority is more urgent.
// Every request gives exactly one result word, shown for one cycle with
// o_valid high in the cycle after acceptance: o_status, o_out_task_id (the
// extracted task, otherwise zero) and o_waiting_count, the occupancy after
// the request, low five bits.
// Throughput is one request per cycle. The slots
// form a shift-register chain in which every slot compares its priority
// with the new word at once, so each request finishes without a stall and
// busy stays low.
// An insert into a full queue is dropped with status full; an extract from
// an empty queue reports status empty.
// Reset empties the queue and clears the strobe; slot contents are not
// cleared. The receiver cannot stall and must take each word as it appears.
// ----------------------------------------------------------------------------
module priority_wait_queue #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  logic       i_req_type,
    input  logic [7:0] i_task_id,
    input  logic [7:0] i_task_priority,
    output logic       o_valid,
    output logic [1:0] o_status,
    output logic [7:0] o_out_task_id,
    output logic [4:0] o_waiting_count
);
    import pwq_pkg::*;

    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    t_cmd          cmd;
    t_stat         stat;
    logic [7:0]    head_task;
    logic [CW-1:0] count;
    logic [CW+4:0] count_ext;

    pwq_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_req_type    (i_req_type),
        .i_stat        (stat),
        .i_head_task   (head_task),
        .o_cmd         (cmd),
        .o_valid       (o_valid),
        .o_status      (o_status),
        .o_out_task_id (o_out_task_id)
    );

    pwq_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_task_id       (i_task_id),
        .i_task_priority (i_task_priority),
        .o_stat          (stat),
        .o_head_task     (head_task),
        .o_count         (count)
    );

    assign count_ext       = {{5{1'b0}}, count};
    assign o_waiting_count = count_ext[4:0];

endmodule

// ===== tb/sv/priority_wait_queue_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Priority wait queue testbench
// Drives insert and extract request words into the queue and compares every
// result word with a table row's expected word where one is given, else with
// a queue model kept in the bench. A short table covers empty, full, tie and
// extreme cases, then random fill and drain runs follow under three sender idle profiles.
// ----------------------------------------------------------------------------
module priority_wait_queue_tb;
    import pwq_pkg::*;

    localparam int DEPTH       = 16;
    localparam int PHASE_WORDS = 475;
    localparam int QUIET_LIMIT = 2000;
    localparam int NUM_ROWS    = 25;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] task_id;
        logic [4:0] count;
    } word_t;

    typedef struct packed {
        logic       req;
        logic [7:0] id;
        logic [7:0] prio;
        logic       typed;
        word_t      want;
    } row_t;

    localparam word_t NONE = '{ST_INSERTED, 8'd0, 5'd0};

    localparam row_t DIR_ROWS [NUM_ROWS] = '{
        '{REQ_EXTRACT, 8'hFF, 8'hFF, 1'b1, '{ST_EMPTY, 8'd0, 5'd0}},
        '{REQ_INSERT,  8'h00, 8'h00, 1'b1, '{ST_INSERTED, 8'd0, 5'd1}},
        '{REQ_INSERT,  8'hFF, 8'hFF, 1'b1, '{ST_INSERTED, 8'd0, 5'd2}},
        '{REQ_INSERT,  8'h55, 8'hFF, 1'b0, NONE},
        '{REQ_INSERT,  8'hAA, 8'h00, 1'b0, NONE},
        '{REQ_INSERT,  8'h12, 8'h80, 1'b0, NONE},
        '{REQ_EXTRACT, 8'h00, 8'h00, 1'b1, '{ST_EXTRACTED, 8'hFF, 5'd4}},
        '{REQ_EXTRACT, 8'h5A, 8'h3C, 1'b0, NONE},
        '{REQ_INSERT,  8'h01, 8'h7F, 1'b0, NONE},
        '{REQ_INSERT,  8'h02, 8'h80, 1'b0, NONE},
        '{REQ_INSERT,  8'h03, 8'h81, 1'b0, NONE},
        '{REQ_INSERT,  8'h04, 8'h01, 1'b0, NONE},
        '{REQ_INSERT,  8'h05, 8'hFE, 1'b0, NONE},
        '{REQ_INSERT,  8'h06, 8'h80, 1'b0, NONE},
        '{REQ_INSERT,  8'h07, 8'h00, 1'b0, NONE},
        '{REQ_INSERT,  8'h08, 8'hFF, 1'b0, NONE},
        '{REQ_INSERT,  8'h09, 8'h40, 1'b0, NONE},
        '{REQ_INSERT,  8'h0A, 8'hC0, 1'b0, NONE},
        '{REQ_INSERT,  8'h0B, 8'h80, 1'b0, NONE},
        '{REQ_INSERT,  8'h0C, 8'h01, 1'b0, NONE},
        '{REQ_INSERT,  8'h0D, 8'h7F, 1'b0, NONE},
        '{REQ_INSERT,  8'h0E, 8'hFF, 1'b1, '{ST_FULL, 8'd0, 5'd16}},
        '{REQ_INSERT,  8'hF0, 8'h00, 1'b1, '{ST_FULL, 8'd0, 5'd16}},
        '{REQ_EXTRACT, 8'h00, 8'h00, 1'b0, NONE},
        '{REQ_INSERT,  8'h0F, 8'h55, 1'b0, NONE}
    };

    logic       i_clk           = 1'b0;
    logic       i_rst_n         = 1'b0;
    logic       start           = 1'b0;
    logic       busy;
    logic       i_req_type      = REQ_INSERT;
    logic [7:0] i_task_id       = 8'd0;
    logic [7:0] i_task_priority = 8'd0;
    logic       o_valid;
    logic [1:0] o_status;
    logic [7:0] o_out_task_id;
    logic [4:0] o_waiting_count;

    logic       typed_on   = 1'b0;
    word_t      typed_want = NONE;

    logic [7:0] model_task [DEPTH];
    logic [7:0] model_prio [DEPTH];
    int         model_len = 0;

    word_t      pending_words [$];
    int         mismatches = 0;
    int         quiet_cycles = 0;

    priority_wait_queue #(
        .QUEUE_DEPTH(DEPTH)
    ) uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_req_type     (i_req_type),
        .i_task_id      (i_task_id),
        .i_task_priority(i_task_priority),
        .o_valid        (o_valid),
        .o_status       (o_status),
        .o_out_task_id  (o_out_task_id),
        .o_waiting_count(o_waiting_count)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Sorted insert after all equal or higher priorities; extract takes slot 0.
    task automatic queue_apply(input logic req, input logic [7:0] id,
                               input logic [7:0] prio, output word_t res);
        int pos;
        logic [7:0] head;
        res = NONE;
        if (req == REQ_INSERT) begin
            if (model_len >= DEPTH) begin
                res.status = ST_FULL;
            end else begin
                pos = model_len;
                for (int i = model_len - 1; i >= 0; i--) begin
                    if (model_prio[i] < prio) begin
                        pos = i;
                    end
                end
                for (int i = model_len; i > pos; i--) begin
                    model_task[i] = model_task[i - 1];
                    model_prio[i] = model_prio[i - 1];
                end
                model_task[pos] = id;
                model_prio[pos] = prio;
                model_len++;
                res.status = ST_INSERTED;
            end
        end else if (model_len == 0) begin
            res.status = ST_EMPTY;
        end else begin
            head = model_task[0];
            for (int i = 1; i < model_len; i++) begin
                model_task[i - 1] = model_task[i];
                model_prio[i - 1] = model_prio[i];
            end
            model_len--;
            res.status  = ST_EXTRACTED;
            res.task_id = head;
        end
        res.count = model_len[4:0];
    endtask

    always @(posedge i_clk) begin
        word_t pred;
        word_t want;
        if (i_rst_n && start && !busy) begin
            queue_apply(i_req_type, i_task_id, i_task_priority, pred);
            pending_words.push_back(typed_on ? typed_want : pred);
        end
        if (o_valid === 1'b1) begin
            if (pending_words.size() == 0) begin
                $error("result word with no request pending");
                mismatches++;
            end else begin
                want = pending_words.pop_front();
                if (o_status !== want.status) begin
                    $error("status: expected %0d, actual %0d", want.status, o_status);
                    mismatches++;
                end
                if (o_out_task_id !== want.task_id) begin
                    $error("out_task_id: expected %0d, actual %0d",
                           want.task_id, o_out_task_id);
                    mismatches++;
                end
                if (o_waiting_count !== want.count) begin
                    $error("waiting_count: expected %0d, actual %0d",
                           want.count, o_waiting_count);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_rst_n && start && !busy) || o_valid === 1'b1) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("priority_wait_queue: mismatch");
            $finish;
        end
    end

    function automatic int idle_gap(input int pct);
        int n;
        n = 0;
        while ($urandom_range(99) < pct) begin
            n++;
        end
        return n;
    endfunction

    task automatic send_word(input logic req, input logic [7:0] id, input logic [7:0] prio,
                             input logic typed, input word_t want, input int gap);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start           <= 1'b1;
        i_req_type      <= req;
        i_task_id       <= id;
        i_task_priority <= prio;
        typed_on        <= typed;
        typed_want      <= want;
        do @(posedge i_clk); while (busy);
    endtask

    task automatic drain_results();
        start <= 1'b0;
        do @(posedge i_clk); while (pending_words.size() != 0);
    endtask

    initial begin
        int idle_pct;
        int seg_left;
        int ins_pct;
        logic req;
        logic [7:0] prio;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < NUM_ROWS; r++) begin
            send_word(DIR_ROWS[r].req, DIR_ROWS[r].id, DIR_ROWS[r].prio,
                      DIR_ROWS[r].typed, DIR_ROWS[r].want, idle_gap(35));
        end

        for (int phase = 0; phase < 3; phase++) begin
            idle_pct = (phase == 0) ? 35 : (phase == 1) ? 75 : 0;
            drain_results();
            seg_left = 0;
            ins_pct  = 50;
            for (int n = 0; n < PHASE_WORDS; n++) begin
                if (seg_left == 0) begin
                    seg_left = $urandom_range(40, 8);
                    case ($urandom_range(2))
                        0: ins_pct = 85;
                        1: ins_pct = 15;
                        default: ins_pct = 50;
                    endcase
                end
                seg_left--;
                req = ($urandom_range(99) < ins_pct) ? REQ_INSERT : REQ_EXTRACT;
                case ($urandom_range(3))
                    0: prio = $urandom_range(1) ? 8'hFF : 8'h00;
                    1: prio = 8'($urandom_range(3));
                    default: prio = 8'($urandom_range(255));
                endcase
                send_word(req, 8'($urandom_range(255)), prio, 1'b0, NONE,
                          idle_gap(idle_pct));
            end
        end

        drain_results();
        repeat (4) @(posedge i_clk);
        if (pending_words.size() != 0) begin
            $error("%0d result words never arrived", pending_words.size());
            mismatches++;
        end
        if (mismatches == 0) begin
            $display("priority_wait_queue: match");
        end else begin
            $display("priority_wait_queue: mismatch");
        end
        $finish;
    end

endmodule
